// ===== hdl/block_access_frequency_counter_unit_macros.svh =====
// Assertion macros used by the block access counter RTL.
`ifndef BLOCK_ACCESS_FREQUENCY_COUNTER_UNIT_MACROS_SVH
`define BLOCK_ACCESS_FREQUENCY_COUNTER_UNIT_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define BAFC_ASSERT_SAME(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define BAFC_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== hdl/bafc_pkg.sv =====
// Package with the item kinds, field widths and result type of the block access counter.
`default_nettype none

package bafc_pkg;

  // Fixed widths of the item fields.
  localparam int ADDR_W   = 16;
  localparam int LEN_W    = 9;
  localparam int TOTAL_W  = 64;
  localparam int REPORT_W = 32;

  // Kind codes carried on the input tuser.
  typedef enum logic [1:0] {
    KIND_READ  = 2'd0,
    KIND_WRITE = 2'd1,
    KIND_QUERY = 2'd2
  } kind_t;

  // One result item.
  typedef struct packed {
    logic [REPORT_W-1:0] block_writes;
    logic [REPORT_W-1:0] block_reads;
    logic [TOTAL_W-1:0]  update_blocks;
    logic [TOTAL_W-1:0]  write_blocks;
    logic [TOTAL_W-1:0]  write_requests;
    logic [TOTAL_W-1:0]  read_blocks;
    logic [TOTAL_W-1:0]  read_requests;
  } result_t;

endpackage

`default_nettype wire

// ===== hdl/bafc_ram.sv =====
// Generic simple dual-port RAM with one write port and one registered read port.
`default_nettype none

module bafc_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 65536
) (
  input  wire logic                     clk,
  input  wire logic                     wr_en,
  input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
  input  wire logic [WIDTH-1:0]         wr_data,
  input  wire logic                     rd_en,
  input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic      [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // Registered read port.
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

`default_nettype wire

// ===== hdl/block_access_frequency_counter_unit.sv =====
// Block access histogram: per-block read and write counters with running totals.
//
// Each input item is a read request, a write request or a query of one block. All per-block
// counters live in one RAM (write counter in the upper half of each word, read counter in the
// lower half) that is walked one block per cycle: a read is issued for one block while the
// previous block is incremented and written back. After reset the block first clears the RAM,
// one entry a cycle, and takes no item until that is done. Then a request walks its blocks
// through the RAM port, which does one read-modify-write per cycle. Exactly one result item
// follows every input item. The result sits in an output register, so the next item is taken
// while it waits.
`default_nettype none
`include "block_access_frequency_counter_unit_macros.svh"

module block_access_frequency_counter_unit #(
  parameter int NUM_BLOCKS  = 65536,
  parameter int MAX_LENGTH  = 256,
  parameter int COUNT_WIDTH = 32
) (
  input  wire logic         clk,
  input  wire logic         rst_n,
  // Input item: bits 15:0 block_address, bits 24:16 length, bits 31:25 zero.
  input  wire logic [31:0]  in_tdata,
  // Input kind: bits 1:0 kind.
  input  wire logic [1:0]   in_tuser,
  input  wire logic         in_tvalid,
  output logic              in_tready,
  // Result item: bits 63:0 read_requests, 127:64 read_blocks, 191:128 write_requests,
  // 255:192 write_blocks, 319:256 update_blocks, 351:320 block_reads, 383:352 block_writes.
  output logic [383:0]      out_tdata,
  // Result flag: bit 0 out_of_range.
  output logic              out_tuser,
  output logic              out_tvalid,
  input  wire logic         out_tready
);

  import bafc_pkg::*;

  localparam int AW    = $clog2(NUM_BLOCKS);
  localparam int CW    = COUNT_WIDTH;
  localparam int SUM_W = (AW + 1 > ADDR_W + 1) ? AW + 1 : ADDR_W + 1;
  localparam logic [AW-1:0]    LAST_BLK = AW'(NUM_BLOCKS - 1);
  localparam logic [SUM_W-1:0] NB_S     = SUM_W'(NUM_BLOCKS);
  localparam logic [CW-1:0]    CNT_MAX  = {CW{1'b1}};

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_WALK,
    ST_QREAD,
    ST_QWAIT,
    ST_DONE
  } state_t;

  // Registers.
  state_t              state_r, state_nxt;
  logic [AW-1:0]       clr_addr_r, clr_addr_nxt;
  kind_t               kind_r, kind_nxt;
  logic [AW-1:0]       cur_r, cur_nxt;
  logic [LEN_W-1:0]    remaining_r, remaining_nxt;
  logic                wb_vld_r, wb_vld_nxt;
  logic [AW-1:0]       wb_addr_r, wb_addr_nxt;
  logic                oor_r, oor_nxt;
  logic [REPORT_W-1:0] qry_reads_r, qry_reads_nxt;
  logic [REPORT_W-1:0] qry_writes_r, qry_writes_nxt;
  logic [TOTAL_W-1:0]  rd_req_r, rd_req_nxt;
  logic [TOTAL_W-1:0]  rd_blk_r, rd_blk_nxt;
  logic [TOTAL_W-1:0]  wr_req_r, wr_req_nxt;
  logic [TOTAL_W-1:0]  wr_blk_r, wr_blk_nxt;
  logic [TOTAL_W-1:0]  upd_blk_r, upd_blk_nxt;
  result_t             out_r, out_nxt;
  logic                out_oor_r, out_oor_nxt;
  logic                out_tvalid_r, out_tvalid_nxt;

  // Counter RAM port signals.
  logic                mem_wr_en;
  logic [AW-1:0]       mem_wr_addr;
  logic [2*CW-1:0]     mem_wr_data;
  logic                mem_rd_en;
  logic [2*CW-1:0]     mem_rd_data;

  // Decoded input item.
  logic                in_accept;
  kind_t               in_kind;
  logic [ADDR_W-1:0]   in_addr;
  logic [LEN_W-1:0]    in_len;
  logic [SUM_W-1:0]    req_end;
  logic                req_bad;
  logic                qry_bad;

  // Counter words read back from the RAM.
  logic [CW-1:0]       rd_cnt;
  logic [CW-1:0]       wr_cnt;
  logic [63:0]         rd_cnt64;
  logic [63:0]         wr_cnt64;

  assign in_tready = (state_r == ST_IDLE);
  assign in_accept = in_tvalid && in_tready;
  assign in_kind   = kind_t'(in_tuser);
  assign in_addr   = in_tdata[ADDR_W-1:0];
  assign in_len    = in_tdata[ADDR_W+LEN_W-1:ADDR_W];

  // Range checks of a request and of a query.
  assign req_end = SUM_W'(in_addr) + SUM_W'(in_len);
  assign req_bad = (32'(in_len) > 32'(MAX_LENGTH)) || (req_end > NB_S);
  assign qry_bad = SUM_W'(in_addr) >= NB_S;

  assign rd_cnt   = mem_rd_data[CW-1:0];
  assign wr_cnt   = mem_rd_data[2*CW-1:CW];
  assign rd_cnt64 = 64'(rd_cnt);
  assign wr_cnt64 = 64'(wr_cnt);

  // Sequencer, walk and write-back logic.
  always_comb begin
    state_nxt      = state_r;
    clr_addr_nxt   = clr_addr_r;
    kind_nxt       = kind_r;
    cur_nxt        = cur_r;
    remaining_nxt  = remaining_r;
    wb_vld_nxt     = 1'b0;
    wb_addr_nxt    = wb_addr_r;
    oor_nxt        = oor_r;
    qry_reads_nxt  = qry_reads_r;
    qry_writes_nxt = qry_writes_r;
    rd_req_nxt     = rd_req_r;
    rd_blk_nxt     = rd_blk_r;
    wr_req_nxt     = wr_req_r;
    wr_blk_nxt     = wr_blk_r;
    upd_blk_nxt    = upd_blk_r;
    out_nxt        = out_r;
    out_oor_nxt    = out_oor_r;
    out_tvalid_nxt = out_tvalid_r;
    mem_wr_en      = 1'b0;
    mem_wr_addr    = wb_addr_r;
    mem_wr_data    = mem_rd_data;
    mem_rd_en      = 1'b0;

    // A taken result frees the output register.
    if (out_tvalid_r && out_tready) begin
      out_tvalid_nxt = 1'b0;
    end

    // Increment and write back the block whose counters arrived this cycle.
    if (wb_vld_r) begin
      mem_wr_en = 1'b1;
      if (kind_r == KIND_WRITE) begin
        mem_wr_data[2*CW-1:CW] = (wr_cnt == CNT_MAX) ? wr_cnt : wr_cnt + CW'(1);
        if (wr_cnt != '0) begin
          upd_blk_nxt = upd_blk_r + TOTAL_W'(1);
        end
      end else begin
        mem_wr_data[CW-1:0] = (rd_cnt == CNT_MAX) ? rd_cnt : rd_cnt + CW'(1);
      end
    end

    case (state_r)
      ST_CLEAR: begin
        mem_wr_en    = 1'b1;
        mem_wr_addr  = clr_addr_r;
        mem_wr_data  = '0;
        clr_addr_nxt = clr_addr_r + AW'(1);
        if (clr_addr_r == LAST_BLK) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (in_accept) begin
          kind_nxt       = in_kind;
          cur_nxt        = AW'(in_addr);
          remaining_nxt  = in_len;
          oor_nxt        = 1'b0;
          qry_reads_nxt  = '0;
          qry_writes_nxt = '0;
          case (in_kind)
            KIND_READ, KIND_WRITE: begin
              if (req_bad) begin
                oor_nxt   = 1'b1;
                state_nxt = ST_DONE;
              end else begin
                if (in_kind == KIND_WRITE) begin
                  wr_req_nxt = wr_req_r + TOTAL_W'(1);
                  wr_blk_nxt = wr_blk_r + TOTAL_W'(in_len);
                end else begin
                  rd_req_nxt = rd_req_r + TOTAL_W'(1);
                  rd_blk_nxt = rd_blk_r + TOTAL_W'(in_len);
                end
                state_nxt = (in_len == '0) ? ST_DONE : ST_WALK;
              end
            end
            KIND_QUERY: begin
              if (qry_bad) begin
                oor_nxt   = 1'b1;
                state_nxt = ST_DONE;
              end else begin
                state_nxt = ST_QREAD;
              end
            end
            default: begin
              state_nxt = ST_DONE;
            end
          endcase
        end
      end
      ST_WALK: begin
        // Read one block per cycle; its write-back follows in the next cycle.
        if (remaining_r != '0) begin
          mem_rd_en     = 1'b1;
          wb_vld_nxt    = 1'b1;
          wb_addr_nxt   = cur_r;
          cur_nxt       = cur_r + AW'(1);
          remaining_nxt = remaining_r - LEN_W'(1);
        end else begin
          state_nxt = ST_DONE;
        end
      end
      ST_QREAD: begin
        mem_rd_en = 1'b1;
        state_nxt = ST_QWAIT;
      end
      ST_QWAIT: begin
        qry_reads_nxt  = (rd_cnt64 > 64'h0000_0000_FFFF_FFFF) ? '1 : rd_cnt64[REPORT_W-1:0];
        qry_writes_nxt = (wr_cnt64 > 64'h0000_0000_FFFF_FFFF) ? '1 : wr_cnt64[REPORT_W-1:0];
        state_nxt      = ST_DONE;
      end
      ST_DONE: begin
        // Load the result once the output register is free.
        if (!out_tvalid_r || out_tready) begin
          out_nxt.read_requests  = rd_req_r;
          out_nxt.read_blocks    = rd_blk_r;
          out_nxt.write_requests = wr_req_r;
          out_nxt.write_blocks   = wr_blk_r;
          out_nxt.update_blocks  = upd_blk_r;
          out_nxt.block_reads    = qry_reads_r;
          out_nxt.block_writes   = qry_writes_r;
          out_oor_nxt            = oor_r;
          out_tvalid_nxt         = 1'b1;
          state_nxt              = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // State and registered outputs.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_CLEAR;
      clr_addr_r   <= '0;
      wb_vld_r     <= 1'b0;
      out_tvalid_r <= 1'b0;
      rd_req_r     <= '0;
      rd_blk_r     <= '0;
      wr_req_r     <= '0;
      wr_blk_r     <= '0;
      upd_blk_r    <= '0;
    end else begin
      state_r      <= state_nxt;
      clr_addr_r   <= clr_addr_nxt;
      wb_vld_r     <= wb_vld_nxt;
      out_tvalid_r <= out_tvalid_nxt;
      rd_req_r     <= rd_req_nxt;
      rd_blk_r     <= rd_blk_nxt;
      wr_req_r     <= wr_req_nxt;
      wr_blk_r     <= wr_blk_nxt;
      upd_blk_r    <= upd_blk_nxt;
    end
    kind_r       <= kind_nxt;
    cur_r        <= cur_nxt;
    remaining_r  <= remaining_nxt;
    wb_addr_r    <= wb_addr_nxt;
    oor_r        <= oor_nxt;
    qry_reads_r  <= qry_reads_nxt;
    qry_writes_r <= qry_writes_nxt;
    out_r        <= out_nxt;
    out_oor_r    <= out_oor_nxt;
  end

  // Per-block read and write counters.
  bafc_ram #(
    .WIDTH (2 * CW),
    .DEPTH (NUM_BLOCKS)
  ) u_count_ram (
    .clk     (clk),
    .wr_en   (mem_wr_en),
    .wr_addr (mem_wr_addr),
    .wr_data (mem_wr_data),
    .rd_en   (mem_rd_en),
    .rd_addr (cur_r),
    .rd_data (mem_rd_data)
  );

  assign out_tdata  = out_r;
  assign out_tuser  = out_oor_r;
  assign out_tvalid = out_tvalid_r;

  // Checks of the walk and the sequencing.
  `BAFC_ASSERT_SAME(a_no_rw_collision, mem_rd_en && wb_vld_r, cur_r != wb_addr_r, "read and write-back hit the same block")
  `BAFC_ASSERT_SAME(a_idle_no_writeback, in_tready, !wb_vld_r, "item taken while a write-back is pending")
  `BAFC_ASSERT_NEXT(a_walk_ends, state_r == ST_WALK && remaining_r == '0, state_r == ST_DONE, "walk did not end in the result state")
  `BAFC_ASSERT_NEXT(a_clear_blocks_items, state_r == ST_CLEAR && clr_addr_r != LAST_BLK, state_r == ST_CLEAR && !in_tready, "clearing pass ended early")

endmodule

`default_nettype wire
